// File: sv/nv21_block_average_mosaic_defines.svh
// Assertion macros for the mosaic block
`ifndef NV21_BLOCK_AVERAGE_MOSAIC_DEFINES_SVH
`define NV21_BLOCK_AVERAGE_MOSAIC_DEFINES_SVH
`ifndef NO_ASSERTIONS
`define NBAM_ASSERT_IMP(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |-> (c)) else $error(msg);
`define NBAM_ASSERT_NXT(label, clk, rst_n, a, c, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (a) |=> (c)) else $error(msg);
`else
`define NBAM_ASSERT_IMP(label, clk, rst_n, a, c, msg)
`define NBAM_ASSERT_NXT(label, clk, rst_n, a, c, msg)
`endif
`endif

// File: sv/nbam_pkg.sv
`timescale 1ns / 1ps
package nbam_pkg;
  localparam int unsigned DefMaxWidth  = 640;
  localparam int unsigned DefMaxHeight = 480;
  localparam int unsigned DefMaxBlock  = 64;
  localparam int unsigned CfgAw = 2;
  localparam int unsigned CfgDw = 10;
  localparam logic [CfgAw-1:0] RegWidth  = 2'd0;
  localparam logic [CfgAw-1:0] RegHeight = 2'd1;
  localparam logic [CfgAw-1:0] RegBlock  = 2'd2;
  localparam logic ReqLoad = 1'b0;
  localparam logic ReqRead = 1'b1;
  localparam logic [7:0] ByteMask = 8'hFF;

  typedef struct packed {
    logic start;
    logic busy;
  } mos_ctl_t;
endpackage

// File: sv/nbam_if.sv
`timescale 1ns / 1ps
interface nbam_in_if;
  logic       valid;
  logic       ready;
  logic       req_type;
  logic [7:0] data_byte;
  modport source (output valid, req_type, data_byte, input ready);
  modport sink (input valid, req_type, data_byte, output ready);
endinterface

// File: sv/nbam_out_if.sv
`timescale 1ns / 1ps
interface nbam_out_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       out_last;
  logic       out_status;
  modport source (output valid, out_byte, out_last, out_status, input ready);
  modport sink (input valid, out_byte, out_last, out_status, output ready);
endinterface

// File: sv/nbam_div.sv
`timescale 1ns / 1ps
// Restoring divider, one quotient bit a cycle. Numerator up to 24 bits.
module nbam_div import nbam_pkg::*; #(
  parameter int unsigned NW = 24,
  parameter int unsigned DW = 16
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic          done,
  output logic [NW-1:0] quo
);
  localparam int unsigned CW = $clog2(NW + 1);
  logic [NW-1:0] q_r, q_nxt;
  logic [DW:0]   rem_r, rem_nxt;
  logic [DW-1:0] den_r;
  logic [CW-1:0] cnt_r;
  logic          busy_r, done_r;
  logic [DW:0]   trial;

  always_comb begin
    trial   = {rem_r[DW-1:0], q_r[NW-1]};
    q_nxt   = {q_r[NW-2:0], 1'b0};
    rem_nxt = trial;
    if (trial >= {1'b0, den_r}) begin
      rem_nxt = trial - {1'b0, den_r};
      q_nxt[0] = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CW'(NW);
      end else if (busy_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == CW'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      q_r   <= num;
      rem_r <= '0;
      den_r <= den;
    end else if (busy_r) begin
      q_r   <= q_nxt;
      rem_r <= rem_nxt;
    end
  end

  assign done = done_r;
  assign quo  = q_r;
endmodule

// File: sv/nv21_block_average_mosaic.sv
`timescale 1ns / 1ps
// Channel  | Dir | Handshake     | Payload
// in       | in  | valid/ready   | req_type, data_byte
// out      | out | valid/ready   | out_byte, out_last, out_status
// cfg      | in  | we only       | cfg_idx, cfg_data
// Load word: written to the store on accept. Readout: accept, store read, output register; next accept once taken.
// First readout after a load runs the mosaic: per luma tile a sum sweep that issues and then
// accumulates a read for each byte, a divide and a write sweep; per chroma tile the read
// states S_CRD0, S_CRD1, S_CRD2 and a write sweep.
// Reset is synchronous, active low; the frame store is not cleared.
// A full output register holds off new input until the word is taken.
`include "nv21_block_average_mosaic_defines.svh"
module nv21_block_average_mosaic import nbam_pkg::*; #(
  parameter int unsigned MAX_WIDTH  = DefMaxWidth,
  parameter int unsigned MAX_HEIGHT = DefMaxHeight,
  parameter int unsigned MAX_BLOCK  = DefMaxBlock
) (
  input  logic              clk,
  input  logic              rst_n,
  nbam_in_if.sink           in_ch,
  nbam_out_if.source        out_ch,
  input  logic              cfg_we,
  input  logic [CfgAw-1:0]  cfg_idx,
  input  logic [CfgDw-1:0]  cfg_data
);
  localparam int unsigned Depth = MAX_WIDTH * MAX_HEIGHT * 3 / 2;
  localparam int unsigned AW    = $clog2(Depth + 1);
  localparam int unsigned XW    = $clog2(MAX_WIDTH + 1);
  localparam int unsigned YW    = $clog2(MAX_HEIGHT + 1);
  localparam int unsigned BW    = $clog2(MAX_BLOCK + 1);
  localparam int unsigned SW    = 8 + 2 * BW;
  localparam int unsigned CntW  = 2 * BW;

  typedef enum logic [3:0] {
    S_IDLE, S_RD, S_RDOUT, S_LSUM, S_LDIV, S_LWR, S_CRD0, S_CRD1, S_CRD2, S_CWR
  } state_t;

  state_t state_r;
  logic [7:0] mem [Depth];
  logic [7:0] rdata_r;
  logic       we;
  logic [AW-1:0] waddr, raddr;
  logic [7:0] wdata;

  logic [9:0] width_r;
  logic [8:0] height_r;
  logic [6:0] block_r;
  logic [AW-1:0] load_pos_r, read_pos_r, total_r;
  logic loaded_r, mos_done_r;

  // geometry, combinational from the config registers
  logic [XW-1:0] w_eff;
  logic [YW-1:0] h_eff;
  logic [BW-1:0] b_eff;
  logic [AW-1:0] total_c;

  // mosaic walker
  logic [YW-1:0] ty_r, y_r, ye_r;
  logic [XW-1:0] tx_r, x_r, xe_r;
  logic [AW-1:0] row_r, addr_r, luma_r;
  logic [SW-1:0] sum_r;
  logic [CntW-1:0] cnt_r;
  logic [7:0] avg_r, v_r, u_r;
  logic       pend_r;   // read data is valid this cycle
  mos_ctl_t   dctl;
  logic       div_done;
  logic [23:0] quo;

  logic ov_r;
  logic [7:0] ob_r;
  logic ol_r, os_r;

  always_comb begin
    logic [XW-1:0] wc;
    logic [YW-1:0] hc;
    wc = (width_r < 10'd2) ? XW'(2) : (32'(width_r) > MAX_WIDTH) ? XW'(MAX_WIDTH)
                                                                 : XW'(width_r);
    hc = (height_r < 9'd2) ? YW'(2) : (32'(height_r) > MAX_HEIGHT) ? YW'(MAX_HEIGHT)
                                                                   : YW'(height_r);
    w_eff = {wc[XW-1:1], 1'b0};
    h_eff = {hc[YW-1:1], 1'b0};
    b_eff = (block_r < 7'd2) ? BW'(2) : (32'(block_r) > MAX_BLOCK) ? BW'(MAX_BLOCK)
                                                                   : BW'(block_r);
  end
  assign total_c = AW'(w_eff * h_eff * 3 / 2);

  logic [XW-1:0] cwid;
  logic [YW-1:0] chgt;
  logic [BW-1:0] cb;
  assign cwid = w_eff >> 1;
  assign chgt = h_eff >> 1;
  assign cb   = b_eff >> 1;

  assign dctl.start = (state_r == S_LSUM) && pend_r && (x_r == xe_r) && (y_r == ye_r);
  assign dctl.busy  = (state_r == S_LDIV);

  nbam_div #(.NW(24), .DW(CntW)) u_div (
    .clk(clk), .rst_n(rst_n), .start(dctl.start),
    .num(24'(sum_r) + 24'(rdata_r)), .den(cnt_r + 1'b1),
    .done(div_done), .quo(quo)
  );

  logic in_fire, out_fire;
  assign in_ch.ready = (state_r == S_IDLE) && !ov_r;
  assign in_fire  = in_ch.valid && in_ch.ready;
  assign out_fire = out_ch.valid && out_ch.ready;

  // memory port select
  always_comb begin
    we = 1'b0; waddr = addr_r; wdata = avg_r; raddr = addr_r;
    unique case (state_r)
      S_IDLE: begin
        raddr = read_pos_r;
        if (in_fire && in_ch.req_type == ReqLoad) begin
          we = 1'b1;
          waddr = (loaded_r || load_pos_r >= total_c) ? '0 : load_pos_r;
          wdata = in_ch.data_byte;
        end
      end
      S_RD: raddr = read_pos_r;
      S_LSUM: if (!pend_r) raddr = row_r + AW'(x_r);
      S_LWR: we = 1'b1;
      S_CWR: begin
        we = 1'b1;
        wdata = x_r[0] ? u_r : v_r;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata_r <= mem[raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      width_r <= 10'd640; height_r <= 9'd480; block_r <= 7'd8;
      load_pos_r <= '0; read_pos_r <= '0;
      loaded_r <= 1'b0; mos_done_r <= 1'b0;
      ov_r <= 1'b0; pend_r <= 1'b0;
    end else begin
      if (out_fire) ov_r <= 1'b0;
      if (cfg_we) begin
        unique case (cfg_idx)
          RegWidth:  width_r  <= cfg_data;
          RegHeight: height_r <= cfg_data[8:0];
          RegBlock:  block_r  <= cfg_data[6:0];
          default: ;
        endcase
        if (cfg_idx == RegWidth || cfg_idx == RegHeight || cfg_idx == RegBlock) begin
          load_pos_r <= '0; read_pos_r <= '0; loaded_r <= 1'b0; mos_done_r <= 1'b0;
        end
      end
      unique case (state_r)
        S_IDLE: if (in_fire) begin
          total_r <= total_c;
          luma_r  <= AW'(w_eff * h_eff);
          if (in_ch.req_type == ReqLoad) begin
            if (loaded_r || load_pos_r >= total_c) begin
              read_pos_r <= '0; mos_done_r <= 1'b0;
              load_pos_r <= AW'(1);
              loaded_r <= (AW'(1) >= total_c);
            end else begin
              load_pos_r <= load_pos_r + 1'b1;
              loaded_r <= (load_pos_r + 1'b1 >= total_c);
            end
          end else if (!loaded_r) begin
            ov_r <= 1'b1; ob_r <= 8'd0; ol_r <= 1'b0; os_r <= 1'b1;
          end else if (!mos_done_r) begin
            ty_r <= '0; tx_r <= '0; y_r <= '0; x_r <= '0; row_r <= '0;
            ye_r <= (YW'(b_eff) < h_eff) ? YW'(b_eff - 1'b1) : h_eff - 1'b1;
            xe_r <= (XW'(b_eff) < w_eff) ? XW'(b_eff - 1'b1) : w_eff - 1'b1;
            addr_r <= '0; sum_r <= '0; cnt_r <= '0; pend_r <= 1'b0;
            state_r <= S_LSUM;
          end else begin
            state_r <= S_RD;
          end
        end
        S_RD: state_r <= S_RDOUT;  // store read of read_pos_r issued here
        S_RDOUT: begin
          ov_r <= 1'b1; ob_r <= rdata_r & ByteMask; os_r <= 1'b0;
          ol_r <= (read_pos_r + 1'b1 == total_r);
          read_pos_r <= (read_pos_r + 1'b1 >= total_r) ? '0 : read_pos_r + 1'b1;
          state_r <= S_IDLE;
        end
        S_LSUM: begin
          // issue address for (y,x), accumulate previous read
          if (pend_r) begin
            sum_r <= sum_r + SW'(rdata_r);
            cnt_r <= cnt_r + 1'b1;
            pend_r <= 1'b0;
            if (x_r == xe_r && y_r == ye_r) begin
              state_r <= S_LDIV;
            end else if (x_r == xe_r) begin
              x_r <= tx_r; y_r <= y_r + 1'b1;
              row_r <= row_r + AW'(w_eff);
            end else x_r <= x_r + 1'b1;
          end else begin
            addr_r <= row_r + AW'(x_r);
            pend_r <= 1'b1;
          end
        end
        S_LDIV: if (div_done) begin
          avg_r <= quo[7:0];
          x_r <= tx_r; y_r <= ty_r;
          row_r <= AW'(ty_r * w_eff);
          addr_r <= AW'(ty_r * w_eff) + AW'(tx_r);
          state_r <= S_LWR;
        end
        S_LWR: begin
          if (x_r == xe_r && y_r == ye_r) begin
            sum_r <= '0; cnt_r <= '0;
            if (32'(tx_r) + 32'(b_eff) < 32'(w_eff)) begin
              tx_r <= tx_r + XW'(b_eff);
              x_r <= tx_r + XW'(b_eff); y_r <= ty_r;
              row_r <= AW'(ty_r * w_eff);
              xe_r <= (32'(tx_r) + 2 * 32'(b_eff) < 32'(w_eff))
                      ? XW'(32'(tx_r) + 2 * 32'(b_eff) - 1) : w_eff - 1'b1;
              state_r <= S_LSUM;
            end else if (32'(ty_r) + 32'(b_eff) < 32'(h_eff)) begin
              ty_r <= ty_r + YW'(b_eff); tx_r <= '0;
              x_r <= '0; y_r <= ty_r + YW'(b_eff);
              row_r <= AW'((ty_r + b_eff) * w_eff);
              ye_r <= (32'(ty_r) + 2 * 32'(b_eff) < 32'(h_eff))
                      ? YW'(32'(ty_r) + 2 * 32'(b_eff) - 1) : h_eff - 1'b1;
              xe_r <= (XW'(b_eff) < w_eff) ? XW'(b_eff - 1'b1) : w_eff - 1'b1;
              state_r <= S_LSUM;
            end else begin
              // chroma: coordinates in pairs, x_r counts bytes
              ty_r <= '0; tx_r <= '0;
              state_r <= S_CRD0;
              addr_r <= luma_r;
              row_r <= luma_r;
              ye_r <= (YW'(cb) < chgt) ? YW'(cb - 1'b1) : chgt - 1'b1;
              xe_r <= (XW'(cb) < cwid) ? XW'(cb - 1'b1) : cwid - 1'b1;
            end
          end else begin
            if (x_r == xe_r) begin
              x_r <= tx_r; y_r <= y_r + 1'b1;
              row_r <= row_r + AW'(w_eff);
              addr_r <= row_r + AW'(w_eff) + AW'(tx_r);
            end else begin
              x_r <= x_r + 1'b1;
              addr_r <= addr_r + 1'b1;
            end
          end
        end
        S_CRD0: begin
          addr_r <= addr_r + 1'b1;
          state_r <= S_CRD1;
        end
        S_CRD1: begin
          v_r <= rdata_r;
          state_r <= S_CRD2;
        end
        S_CRD2: begin
          u_r <= rdata_r;
          x_r <= {tx_r[XW-2:0], 1'b0}; y_r <= ty_r;
          addr_r <= row_r + AW'({tx_r[XW-2:0], 1'b0});
          state_r <= S_CWR;
        end
        S_CWR: begin
          if (x_r == {xe_r[XW-2:0], 1'b1} && y_r == ye_r) begin
            if (32'(tx_r) + 32'(cb) < 32'(cwid)) begin
              tx_r <= tx_r + XW'(cb);
              row_r <= luma_r + AW'(ty_r * w_eff);
              addr_r <= luma_r + AW'(ty_r * w_eff) + AW'(2 * (tx_r + cb));
              xe_r <= (32'(tx_r) + 2 * 32'(cb) < 32'(cwid))
                      ? XW'(32'(tx_r) + 2 * 32'(cb) - 1) : cwid - 1'b1;
              state_r <= S_CRD0;
            end else if (32'(ty_r) + 32'(cb) < 32'(chgt)) begin
              ty_r <= ty_r + YW'(cb); tx_r <= '0;
              row_r <= luma_r + AW'((ty_r + cb) * w_eff);
              addr_r <= luma_r + AW'((ty_r + cb) * w_eff);
              ye_r <= (32'(ty_r) + 2 * 32'(cb) < 32'(chgt))
                      ? YW'(32'(ty_r) + 2 * 32'(cb) - 1) : chgt - 1'b1;
              xe_r <= (XW'(cb) < cwid) ? XW'(cb - 1'b1) : cwid - 1'b1;
              state_r <= S_CRD0;
            end else begin
              mos_done_r <= 1'b1;
              addr_r <= read_pos_r;
              state_r <= S_RD;
            end
          end else if (x_r == {xe_r[XW-2:0], 1'b1}) begin
            x_r <= {tx_r[XW-2:0], 1'b0}; y_r <= y_r + 1'b1;
            row_r <= row_r + AW'(w_eff);
            addr_r <= row_r + AW'(w_eff) + AW'({tx_r[XW-2:0], 1'b0});
          end else begin
            x_r <= x_r + 1'b1;
            addr_r <= addr_r + 1'b1;
          end
        end
        default: state_r <= S_IDLE;
      endcase
    end
  end

  assign out_ch.valid      = ov_r;
  assign out_ch.out_byte   = ob_r;
  assign out_ch.out_last   = ol_r;
  assign out_ch.out_status = os_r;

  `NBAM_ASSERT_IMP(a_busy_no_accept, clk, rst_n, dctl.busy, !in_ch.ready, "accept in divide")
  `NBAM_ASSERT_IMP(a_ready_idle, clk, rst_n, in_ch.ready, state_r == S_IDLE, "ready while busy")
  `NBAM_ASSERT_IMP(a_div_in_pass, clk, rst_n, div_done, state_r == S_LDIV, "stray divide")
  `NBAM_ASSERT_IMP(a_err_zero, clk, rst_n, ov_r && os_r, ob_r == 8'd0 && !ol_r, "error word")
endmodule
